### hw/rtl/bmhq_pkg.sv
// shared constants for the binary min-heap queue
package bmhq_pkg;

    // command codes on the input channel
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    // fixed widths of the channel fields
    localparam int VALUE_PORT_W    = 32;
    localparam int PRIORITY_PORT_W = 32;
    localparam int COUNT_PORT_W    = 11;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

endpackage

### hw/rtl/bmhq_front.sv
// input front: accepts items, decodes the command and queues it for the heap engine
module bmhq_front
    import bmhq_pkg::*;
#(
    parameter int VALUE_BITS    = 32,
    parameter int PRIORITY_BITS = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_cmd,
    input  logic [VALUE_PORT_W-1:0]    s_item_value,
    input  logic [PRIORITY_PORT_W-1:0] s_item_priority,
    output logic                       q_valid,
    input  logic                       q_ready,
    output logic                       q_is_delete,
    output logic [VALUE_BITS-1:0]      q_value,
    output logic [PRIORITY_BITS-1:0]   q_priority
);

    localparam int QW = 1 + VALUE_BITS + PRIORITY_BITS;

    logic [QW-1:0]     fifo_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   fill_reg, fill_next;
    logic              push, pop;
    logic [QW-1:0]     in_entry;
    logic [QW-1:0]     head;

    assign s_ready = (fill_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_valid = (fill_reg != '0);
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    // truncate the fields and classify the command
    assign in_entry = {(s_cmd == CMD_DELETE),
                       s_item_value[VALUE_BITS-1:0],
                       s_item_priority[PRIORITY_BITS-1:0]};

    assign head        = fifo_reg[rd_ptr_reg];
    assign q_is_delete = head[QW-1];
    assign q_value     = head[QW-2 -: VALUE_BITS];
    assign q_priority  = head[PRIORITY_BITS-1:0];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop) begin
            fill_next = fill_reg + (QPTR_W+1)'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= in_entry;
        end
    end

endmodule

### hw/rtl/bmhq_engine.sv
// heap engine: slot memory, sift-up and sift-down sequencer and result register
module bmhq_engine
    import bmhq_pkg::*;
#(
    parameter int CAPACITY      = 1024,
    parameter int VALUE_BITS    = 32,
    parameter int PRIORITY_BITS = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       q_valid,
    output logic                       q_ready,
    input  logic                       q_is_delete,
    input  logic [VALUE_BITS-1:0]      q_value,
    input  logic [PRIORITY_BITS-1:0]   q_priority,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [VALUE_PORT_W-1:0]    m_popped_value,
    output logic [PRIORITY_PORT_W-1:0] m_popped_priority,
    output logic [COUNT_PORT_W-1:0]    m_entry_count,
    output logic                       m_empty_error,
    output logic                       m_full_error
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = CW + 1;
    localparam int EW = VALUE_BITS + PRIORITY_BITS;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_UP_CMP  = 3'd1;
    localparam logic [2:0] ST_DN_LOAD = 3'd2;
    localparam logic [2:0] ST_DN_CMP  = 3'd3;
    localparam logic [2:0] ST_FIN     = 3'd4;

    // entry layout: {priority, value}
    logic [EW-1:0] mem [CAPACITY];
    logic [EW-1:0] rd_a_reg, rd_b_reg;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [EW-1:0] mov_reg, mov_next;
    logic [EW-1:0] pop_reg, pop_next;

    logic          m_valid_reg;
    logic [EW-1:0] res_entry_reg;
    logic [CW-1:0] res_count_reg;
    logic          res_empty_reg, res_full_reg;

    logic [AW-1:0] rd_addr_a, rd_addr_b, waddr;
    logic          we;
    logic [EW-1:0] wdata;
    logic          res_load;
    logic [EW-1:0] res_entry;
    logic          res_empty, res_full;

    logic          out_free, take;
    logic [AW-1:0] par, gpar;
    logic [KW-1:0] pos_ext, cnt_ext, kid_l, kid_r, ch, ch_l, ch_r;
    logic          right_wins;
    logic [EW-1:0] ch_e;
    logic [PRIORITY_BITS-1:0] mov_pri, a_pri, b_pri;

    assign out_free = !m_valid_reg || m_ready;
    assign q_ready  = (state_reg == ST_IDLE) && out_free;
    assign take     = q_valid && q_ready;

    assign mov_pri = mov_reg[EW-1:VALUE_BITS];
    assign a_pri   = rd_a_reg[EW-1:VALUE_BITS];
    assign b_pri   = rd_b_reg[EW-1:VALUE_BITS];

    // parent walk for sift-up
    assign par  = (pos_reg - AW'(1)) >> 1;
    assign gpar = (par - AW'(1)) >> 1;

    // child selection for sift-down
    assign pos_ext    = KW'(pos_reg);
    assign cnt_ext    = KW'(count_reg);
    assign kid_l      = {pos_ext[KW-2:0], 1'b0} | KW'(1);
    assign kid_r      = kid_l + KW'(1);
    assign right_wins = (kid_r < cnt_ext) && (b_pri < a_pri);
    assign ch         = right_wins ? kid_r : kid_l;
    assign ch_e       = right_wins ? rd_b_reg : rd_a_reg;
    assign ch_l       = {ch[KW-2:0], 1'b0} | KW'(1);
    assign ch_r       = ch_l + KW'(1);

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        mov_next   = mov_reg;
        pop_next   = pop_reg;
        rd_addr_a  = '0;
        rd_addr_b  = '0;
        we         = 1'b0;
        waddr      = pos_reg;
        wdata      = mov_reg;
        res_load   = 1'b0;
        res_entry  = '0;
        res_empty  = 1'b0;
        res_full   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    if (!q_is_delete) begin
                        if (count_reg == CW'(CAPACITY)) begin
                            res_load = 1'b1;
                            res_full = 1'b1;
                        end else begin
                            mov_next   = {q_priority, q_value};
                            pop_next   = '0;
                            pos_next   = AW'(count_reg);
                            count_next = count_reg + CW'(1);
                            if (count_reg == '0) begin
                                we       = 1'b1;
                                waddr    = '0;
                                wdata    = {q_priority, q_value};
                                res_load = 1'b1;
                            end else begin
                                rd_addr_a  = AW'((count_reg - CW'(1)) >> 1);
                                state_next = ST_UP_CMP;
                            end
                        end
                    end else begin
                        if (count_reg == '0) begin
                            res_load  = 1'b1;
                            res_empty = 1'b1;
                        end else begin
                            // fetch root and last entry together
                            rd_addr_a  = '0;
                            rd_addr_b  = AW'(count_reg - CW'(1));
                            count_next = count_reg - CW'(1);
                            state_next = ST_DN_LOAD;
                        end
                    end
                end
            end
            ST_UP_CMP: begin
                we = 1'b1;
                if (mov_pri >= a_pri) begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    // parent moves down, keep climbing
                    wdata    = rd_a_reg;
                    pos_next = par;
                    if (par == '0) begin
                        state_next = ST_FIN;
                    end else begin
                        rd_addr_a = gpar;
                    end
                end
            end
            ST_DN_LOAD: begin
                pop_next = rd_a_reg;
                mov_next = rd_b_reg;
                pos_next = '0;
                if (cnt_ext > KW'(1)) begin
                    rd_addr_a  = AW'(1);
                    rd_addr_b  = (cnt_ext > KW'(2)) ? AW'(2) : AW'(1);
                    state_next = ST_DN_CMP;
                end else begin
                    we         = 1'b1;
                    waddr      = '0;
                    wdata      = rd_b_reg;
                    res_load   = 1'b1;
                    res_entry  = rd_a_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_DN_CMP: begin
                we = 1'b1;
                if (mov_pri <= ch_e[EW-1:VALUE_BITS]) begin
                    res_load   = 1'b1;
                    res_entry  = pop_reg;
                    state_next = ST_IDLE;
                end else begin
                    // smaller child moves up, descend into its slot
                    wdata    = ch_e;
                    pos_next = AW'(ch);
                    if (ch_l < cnt_ext) begin
                        rd_addr_a = AW'(ch_l);
                        rd_addr_b = (ch_r < cnt_ext) ? AW'(ch_r) : AW'(ch_l);
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                we         = 1'b1;
                res_load   = 1'b1;
                res_entry  = pop_reg;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg <= pos_next;
        mov_reg <= mov_next;
        pop_reg <= pop_next;
        if (res_load) begin
            res_entry_reg <= res_entry;
            res_count_reg <= count_next;
            res_empty_reg <= res_empty;
            res_full_reg  <= res_full;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_popped_value    = VALUE_PORT_W'({{VALUE_PORT_W{1'b0}},
                                              res_entry_reg[VALUE_BITS-1:0]});
    assign m_popped_priority = PRIORITY_PORT_W'({{PRIORITY_PORT_W{1'b0}},
                                                 res_entry_reg[EW-1:VALUE_BITS]});
    assign m_entry_count     = COUNT_PORT_W'({{COUNT_PORT_W{1'b0}}, res_count_reg});
    assign m_empty_error     = res_empty_reg;
    assign m_full_error      = res_full_reg;

endmodule

### hw/rtl/binary_min_heap_queue_core.sv
// binary min-heap priority queue: how an item passes through the core
// an item is registered in the input queue, then the heap engine runs it:
// insert sifts up, delete sifts down; the engine takes a new command only when idle
// one sift level per cycle, set by the single write port of the slot memory
// the result is registered; an error result loads as the engine takes the command
// reset clears the count, the input queue and the result valid; slots are not cleared
module binary_min_heap_queue_core
    import bmhq_pkg::*;
#(
    parameter int CAPACITY      = 1024,
    parameter int VALUE_BITS    = 32,
    parameter int PRIORITY_BITS = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_cmd,
    input  logic [VALUE_PORT_W-1:0]    s_item_value,
    input  logic [PRIORITY_PORT_W-1:0] s_item_priority,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [VALUE_PORT_W-1:0]    m_popped_value,
    output logic [PRIORITY_PORT_W-1:0] m_popped_priority,
    output logic [COUNT_PORT_W-1:0]    m_entry_count,
    output logic                       m_empty_error,
    output logic                       m_full_error
);

    logic                     q_valid;
    logic                     q_ready;
    logic                     q_is_delete;
    logic [VALUE_BITS-1:0]    q_value;
    logic [PRIORITY_BITS-1:0] q_priority;

    bmhq_front #(
        .VALUE_BITS    (VALUE_BITS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_item_value    (s_item_value),
        .s_item_priority (s_item_priority),
        .q_valid         (q_valid),
        .q_ready         (q_ready),
        .q_is_delete     (q_is_delete),
        .q_value         (q_value),
        .q_priority      (q_priority)
    );

    bmhq_engine #(
        .CAPACITY      (CAPACITY),
        .VALUE_BITS    (VALUE_BITS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_engine (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .q_valid           (q_valid),
        .q_ready           (q_ready),
        .q_is_delete       (q_is_delete),
        .q_value           (q_value),
        .q_priority        (q_priority),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_popped_value    (m_popped_value),
        .m_popped_priority (m_popped_priority),
        .m_entry_count     (m_entry_count),
        .m_empty_error     (m_empty_error),
        .m_full_error      (m_full_error)
    );

endmodule

### sim/tb_binary_min_heap_queue_core.sv
// testbench for the binary min-heap queue core: random and directed commands against a predictor
`timescale 1ns / 1ps

module tb_binary_min_heap_queue_core
    import bmhq_pkg::*;
();

    localparam int CAPACITY      = 1024;
    localparam int MAX_GAP       = 16;
    localparam int WATCHDOG_MAX  = 1000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 340;

    typedef struct packed {
        logic                       cmd;
        logic [VALUE_PORT_W-1:0]    value;
        logic [PRIORITY_PORT_W-1:0] prio;
    } heap_cmd_t;

    typedef struct packed {
        logic [VALUE_PORT_W-1:0]    value;
        logic [PRIORITY_PORT_W-1:0] prio;
        logic [COUNT_PORT_W-1:0]    count;
        logic                       empty_err;
        logic                       full_err;
    } pop_result_t;

    logic                       aclk            = 1'b0;
    logic                       aresetn         = 1'b0;
    logic                       s_valid         = 1'b0;
    logic                       s_ready;
    logic                       s_cmd           = CMD_INSERT;
    logic [VALUE_PORT_W-1:0]    s_item_value    = '0;
    logic [PRIORITY_PORT_W-1:0] s_item_priority = '0;
    logic                       m_valid;
    logic                       m_ready         = 1'b0;
    logic [VALUE_PORT_W-1:0]    m_popped_value;
    logic [PRIORITY_PORT_W-1:0] m_popped_priority;
    logic [COUNT_PORT_W-1:0]    m_entry_count;
    logic                       m_empty_error;
    logic                       m_full_error;

    binary_min_heap_queue_core #(
        .CAPACITY      (CAPACITY),
        .VALUE_BITS    (VALUE_PORT_W),
        .PRIORITY_BITS (PRIORITY_PORT_W)
    ) u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_cmd             (s_cmd),
        .s_item_value      (s_item_value),
        .s_item_priority   (s_item_priority),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_popped_value    (m_popped_value),
        .m_popped_priority (m_popped_priority),
        .m_entry_count     (m_entry_count),
        .m_empty_error     (m_empty_error),
        .m_full_error      (m_full_error)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // shadow heap
    logic [VALUE_PORT_W-1:0]    heap_val [CAPACITY];
    logic [PRIORITY_PORT_W-1:0] heap_pri [CAPACITY];
    int                         heap_size = 0;

    heap_cmd_t   pending_cmds[$];
    pop_result_t expected_pops[$];
    heap_cmd_t   drv_cmd;
    bit          cmd_taken   = 1'b0;
    bit          pop_taken   = 1'b0;
    bit          send_burst  = 1'b0;
    bit          recv_burst  = 1'b0;
    int          send_gap    = 0;
    int          recv_stall  = 0;
    int          plan_size   = 0;
    int          queued_cmds = 0;
    int          checked_pops = 0;
    int          error_count = 0;
    int          idle_cycles = 0;

    function automatic pop_result_t apply_heap_cmd(heap_cmd_t c);
        pop_result_t                r;
        int                         pos;
        int                         up;
        int                         kid;
        bit                         moving;
        logic [VALUE_PORT_W-1:0]    mv;
        logic [PRIORITY_PORT_W-1:0] mp;
        r = '0;
        if (c.cmd == CMD_INSERT) begin
            if (heap_size >= CAPACITY) begin
                r.full_err = 1'b1;
            end else begin
                pos = heap_size;
                heap_size++;
                moving = 1'b1;
                while (moving && pos > 0) begin
                    up = (pos - 1) / 2;
                    if (c.prio >= heap_pri[up]) begin
                        moving = 1'b0;
                    end else begin
                        heap_val[pos] = heap_val[up];
                        heap_pri[pos] = heap_pri[up];
                        pos = up;
                    end
                end
                heap_val[pos] = c.value;
                heap_pri[pos] = c.prio;
            end
        end else begin
            if (heap_size == 0) begin
                r.empty_err = 1'b1;
            end else begin
                r.value = heap_val[0];
                r.prio  = heap_pri[0];
                heap_size--;
                mv = heap_val[heap_size];
                mp = heap_pri[heap_size];
                pos = 0;
                kid = 1;
                moving = 1'b1;
                while (moving && kid < heap_size) begin
                    // right child only when strictly smaller
                    if (kid + 1 < heap_size && heap_pri[kid + 1] < heap_pri[kid])
                        kid++;
                    if (mp <= heap_pri[kid]) begin
                        moving = 1'b0;
                    end else begin
                        heap_val[pos] = heap_val[kid];
                        heap_pri[pos] = heap_pri[kid];
                        pos = kid;
                        kid = 2 * pos + 1;
                    end
                end
                heap_val[pos] = mv;
                heap_pri[pos] = mp;
            end
        end
        r.count = COUNT_PORT_W'(heap_size);
        return r;
    endfunction

    // accept side of both channels, prediction and compare
    always @(posedge aclk) begin
        pop_result_t exp_pop;
        if (aresetn && s_valid && s_ready) begin
            expected_pops.push_back(apply_heap_cmd(drv_cmd));
            cmd_taken = 1'b1;
        end
        if (aresetn && m_valid && m_ready) begin
            pop_taken = 1'b1;
            if (expected_pops.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result: val=%h pri=%h cnt=%0d ee=%b fe=%b",
                             m_popped_value, m_popped_priority, m_entry_count,
                             m_empty_error, m_full_error);
            end else begin
                exp_pop = expected_pops.pop_front();
                checked_pops++;
                if (m_popped_value !== exp_pop.value || m_popped_priority !== exp_pop.prio ||
                    m_entry_count !== exp_pop.count || m_empty_error !== exp_pop.empty_err ||
                    m_full_error !== exp_pop.full_err) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("mismatch: exp val=%h pri=%h cnt=%0d ee=%b fe=%b",
                                 exp_pop.value, exp_pop.prio, exp_pop.count,
                                 exp_pop.empty_err, exp_pop.full_err);
                        $display("          got val=%h pri=%h cnt=%0d ee=%b fe=%b",
                                 m_popped_value, m_popped_priority, m_entry_count,
                                 m_empty_error, m_full_error);
                    end
                end
            end
        end
    end

    // command driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || cmd_taken) begin
            cmd_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                drv_cmd = pending_cmds.pop_front();
                s_cmd           <= drv_cmd.cmd;
                s_item_value    <= drv_cmd.value;
                s_item_priority <= drv_cmd.prio;
                s_valid         <= 1'b1;
                if ($urandom_range(0, 39) == 0)
                    send_burst = !send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver with random stalls
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (pop_taken) begin
                pop_taken = 1'b0;
                if ($urandom_range(0, 39) == 0)
                    recv_burst = !recv_burst;
                recv_stall = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_MAX) begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_MAX);
            $display("tb_binary_min_heap_queue_core: done, errors");
            $finish;
        end
    end

    task automatic queue_insert(input logic [VALUE_PORT_W-1:0] value,
                                input logic [PRIORITY_PORT_W-1:0] prio);
        heap_cmd_t c;
        c.cmd   = CMD_INSERT;
        c.value = value;
        c.prio  = prio;
        pending_cmds.push_back(c);
        queued_cmds++;
        if (plan_size < CAPACITY)
            plan_size++;
    endtask

    task automatic queue_delete();
        heap_cmd_t c;
        c.cmd   = CMD_DELETE;
        c.value = $urandom;
        c.prio  = $urandom;
        pending_cmds.push_back(c);
        queued_cmds++;
        if (plan_size > 0)
            plan_size--;
    endtask

    task automatic wait_all_popped();
        while (checked_pops != queued_cmds)
            @(negedge aclk);
    endtask

    function automatic logic [PRIORITY_PORT_W-1:0] random_prio();
        case ($urandom_range(0, 3))
            0, 1:    return $urandom;
            2:       return $urandom_range(0, 7);
            default: return 32'hFFFF_FFF8 + $urandom_range(0, 7);
        endcase
    endfunction

    initial begin
        int insert_pct;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: empty delete, extremes, ties on the way up and down
        queue_delete();
        queue_insert(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_insert(32'h0000_0000, 32'h0000_0000);
        queue_insert(32'h5555_5555, 32'd5);
        queue_insert(32'hAAAA_AAAA, 32'd5);
        queue_insert(32'h0000_0001, 32'd5);
        queue_insert(32'h0000_0002, 32'h8000_0000);
        queue_insert(32'h0000_0003, 32'd1);
        repeat (8) queue_delete();
        for (int i = 0; i < 4; i++)
            queue_insert(32'd10 + i, 32'd9);
        repeat (4) queue_delete();
        wait_all_popped();

        // random mix in regimes that grow, hold or shrink the heap
        insert_pct = 50;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 50 == 0) begin
                case ($urandom_range(0, 2))
                    0:       insert_pct = 30;
                    1:       insert_pct = 50;
                    default: insert_pct = 75;
                endcase
            end
            if (i == RANDOM_ITEMS / 2)
                wait_all_popped();
            if ($urandom_range(0, 99) < insert_pct)
                queue_insert($urandom, random_prio());
            else
                queue_delete();
        end
        wait_all_popped();

        // drain past empty
        while (plan_size > 0)
            queue_delete();
        repeat (2) queue_delete();

        wait_all_popped();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (error_count == 0 && expected_pops.size() == 0)
            $display("tb_binary_min_heap_queue_core: done, clean");
        else
            $display("tb_binary_min_heap_queue_core: done, errors");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/bmhq_pkg.sv
hw/rtl/bmhq_front.sv
hw/rtl/bmhq_engine.sv
hw/rtl/binary_min_heap_queue_core.sv
sim/tb_binary_min_heap_queue_core.sv
